@@ sv/jaas_pkg.sv @@
// Shared types and constants for the joystick axis auto-calibrating scaler.
// Used by jaas_ctrl, jaas_dp and the top level.
package jaas_pkg;

  localparam int SAMPLE_W = 8;
  localparam int PCT_W    = 8;
  localparam int DIR_W    = 2;
  localparam int CFG_IDX_W = 3;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_NEUTRAL = 2'd0;
  localparam logic [DIR_W-1:0] DIR_ABOVE   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_BELOW   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_BAND_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_BAND_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_BAND_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_BAND_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_START_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_X_START_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Y_START_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_Y_START_HIGH = 3'd7;

  // reset values
  localparam logic [SAMPLE_W-1:0] RST_BAND_LOW   = 8'd118;
  localparam logic [SAMPLE_W-1:0] RST_BAND_HIGH  = 8'd138;
  localparam logic [SAMPLE_W-1:0] RST_START_LOW  = 8'd100;
  localparam logic [SAMPLE_W-1:0] RST_START_HIGH = 8'd156;

  localparam int PCT_FULL  = 100;
  localparam int PROD_W    = 15;   // 255 * 100 fits
  localparam int DIVD_W    = 16;   // dividend / quotient register
  localparam int DIV_STEPS = DIVD_W / 2;   // two quotient bits per cycle
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_DIV   = 5'b00100,
    S_STORE = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  typedef struct packed {
    logic capture;    // latch input samples
    logic setup;      // widen range, form dividend/divisor for axis
    logic div_step;   // one radix-4 divider step
    logic store;      // saturate and keep axis result
    logic load_out;   // move both results into output register
    logic axis;       // 0 = X, 1 = Y
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;   // output register holds a beat that is stalled
  } dp_status_t;

endpackage

@@ sv/jaas_ctrl.sv @@
// Sequencer for the joystick scaler: steps both axes through setup,
// serial division and result store. Depends on jaas_pkg.
module jaas_ctrl import jaas_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t           state, state_next;
  logic             axis, axis_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    axis_next    = axis;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.axis     = axis;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          axis_next   = 1'b0;
          state_next  = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_LAST) state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_SETUP;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a beat is still in work");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && cnt == CNT_LAST |=> state == S_STORE)
    else $error("divider did not finish after last step");

  a_y_after_x: assert property (@(posedge clk) disable iff (rst)
    state == S_STORE && axis |=> state == S_OUT)
    else $error("Y axis store not followed by output");

endmodule

@@ sv/jaas_dp.sv @@
// Datapath for the joystick scaler: config and range registers, axis setup,
// shared radix-4 restoring divider, result saturation and output register.
// Depends on jaas_pkg; driven by jaas_ctrl commands.
module jaas_dp import jaas_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 cmd,
  output dp_status_t                status,
  input  logic                      cfg_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SAMPLE_W-1:0]       cfg_data,
  input  logic [SAMPLE_W-1:0]       x_sample,
  input  logic [SAMPLE_W-1:0]       y_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [PCT_W-1:0]   x_percent,
  output logic [DIR_W-1:0]          x_dir,
  output logic signed [PCT_W-1:0]   y_percent,
  output logic [DIR_W-1:0]          y_dir
);

  logic [SAMPLE_W-1:0] x_band_low, x_band_high, y_band_low, y_band_high;
  logic [SAMPLE_W-1:0] x_seen_low, x_seen_high, y_seen_low, y_seen_high;
  logic [SAMPLE_W-1:0] xs, ys;

  logic [DIVD_W-1:0]   dd;      // dividend in, quotient out
  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] dmag;
  logic                rneg;
  logic [DIR_W-1:0]    dir_r;

  logic signed [PCT_W-1:0] x_pct_r, y_pct_r;
  logic [DIR_W-1:0]        x_dir_r, y_dir_r;

  // axis setup
  logic [SAMPLE_W-1:0] s, bl, bh, lo, hi, lo_n, hi_n, zero;
  logic [SAMPLE_W:0]   band_sum, num, den;
  logic [SAMPLE_W-1:0] num_mag, den_mag;
  logic                above, below;
  logic [PROD_W-1:0]   prod;
  logic [DIR_W-1:0]    dir_c;

  always_comb begin
    s  = cmd.axis ? ys : xs;
    bl = cmd.axis ? y_band_low  : x_band_low;
    bh = cmd.axis ? y_band_high : x_band_high;
    lo = cmd.axis ? y_seen_low  : x_seen_low;
    hi = cmd.axis ? y_seen_high : x_seen_high;
    hi_n = (s > hi) ? s : hi;
    lo_n = (s < lo) ? s : lo;
    band_sum = {1'b0, bl} + {1'b0, bh};
    zero     = SAMPLE_W'(band_sum >> 1);
    above = (s > bh);
    below = !above && (s < bl);
    num = {1'b0, s} - {1'b0, zero};
    den = above ? ({1'b0, hi_n} - {1'b0, zero}) : ({1'b0, lo_n} - {1'b0, zero});
    num_mag = num[SAMPLE_W] ? SAMPLE_W'(-num) : num[SAMPLE_W-1:0];
    den_mag = den[SAMPLE_W] ? SAMPLE_W'(-den) : den[SAMPLE_W-1:0];
    prod = PROD_W'({{(PROD_W-SAMPLE_W){1'b0}}, num_mag} * PROD_W'(PCT_FULL));
    if (above)      dir_c = DIR_ABOVE;
    else if (below) dir_c = DIR_BELOW;
    else            dir_c = DIR_NEUTRAL;
    if (den_mag == '0) dir_c = DIR_NEUTRAL;
  end

  // two restoring steps per cycle
  logic [SAMPLE_W:0]   r1, r2;
  logic                ge1, ge2;
  logic [SAMPLE_W-1:0] r1s, r2s;

  always_comb begin
    r1  = {rem, dd[DIVD_W-1]};
    ge1 = (r1 >= {1'b0, dmag});
    r1s = ge1 ? SAMPLE_W'(r1 - {1'b0, dmag}) : r1[SAMPLE_W-1:0];
    r2  = {r1s, dd[DIVD_W-2]};
    ge2 = (r2 >= {1'b0, dmag});
    r2s = ge2 ? SAMPLE_W'(r2 - {1'b0, dmag}) : r2[SAMPLE_W-1:0];
  end

  // saturate quotient and apply sign rules
  logic [PCT_W-2:0]        mag;
  logic signed [PCT_W-1:0] pct_c;

  always_comb begin
    mag = (dd > DIVD_W'(PCT_FULL)) ? (PCT_W-1)'(PCT_FULL) : dd[PCT_W-2:0];
    case (dir_r)
      DIR_ABOVE: pct_c = rneg ? '0 : {1'b0, mag};
      DIR_BELOW: pct_c = rneg ? -$signed({1'b0, mag}) : '0;
      default:   pct_c = '0;
    endcase
  end

  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_band_low  <= RST_BAND_LOW;
      x_band_high <= RST_BAND_HIGH;
      y_band_low  <= RST_BAND_LOW;
      y_band_high <= RST_BAND_HIGH;
      x_seen_low  <= RST_START_LOW;
      x_seen_high <= RST_START_HIGH;
      y_seen_low  <= RST_START_LOW;
      y_seen_high <= RST_START_HIGH;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_X_BAND_LOW:   x_band_low  <= cfg_data;
          REG_X_BAND_HIGH:  x_band_high <= cfg_data;
          REG_Y_BAND_LOW:   y_band_low  <= cfg_data;
          REG_Y_BAND_HIGH:  y_band_high <= cfg_data;
          REG_X_START_LOW:  x_seen_low  <= cfg_data;
          REG_X_START_HIGH: x_seen_high <= cfg_data;
          REG_Y_START_LOW:  y_seen_low  <= cfg_data;
          REG_Y_START_HIGH: y_seen_high <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.setup) begin
        if (cmd.axis) begin
          y_seen_low  <= lo_n;
          y_seen_high <= hi_n;
        end else begin
          x_seen_low  <= lo_n;
          x_seen_high <= hi_n;
        end
      end
      if (cmd.load_out)                out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xs <= x_sample;
      ys <= y_sample;
    end
    if (cmd.setup) begin
      dd    <= {{(DIVD_W-PROD_W){1'b0}}, prod};
      rem   <= '0;
      dmag  <= den_mag;
      rneg  <= num[SAMPLE_W] ^ den[SAMPLE_W] ^ below;
      dir_r <= dir_c;
    end else if (cmd.div_step) begin
      dd  <= {dd[DIVD_W-3:0], ge1, ge2};
      rem <= r2s;
    end
    if (cmd.store) begin
      if (cmd.axis) begin
        y_pct_r <= pct_c;
        y_dir_r <= dir_r;
      end else begin
        x_pct_r <= pct_c;
        x_dir_r <= dir_r;
      end
    end
    if (cmd.load_out) begin
      x_percent <= x_pct_r;
      x_dir     <= x_dir_r;
      y_percent <= y_pct_r;
      y_dir     <= y_dir_r;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && dmag != '0 && rem < dmag |=> rem < dmag)
    else $error("divider remainder escaped divisor bound");

  a_x_neutral: assert property (@(posedge clk) disable iff (rst)
    out_valid && x_dir == DIR_NEUTRAL |-> x_percent == '0)
    else $error("X neutral beat with nonzero percent");

  a_y_neutral: assert property (@(posedge clk) disable iff (rst)
    out_valid && y_dir == DIR_NEUTRAL |-> y_percent == '0)
    else $error("Y neutral beat with nonzero percent");

endmodule

@@ sv/joystick_axis_autocal_scaler_unit.sv @@
// Top level of the joystick axis auto-calibrating scaler.
// Instantiates jaas_ctrl and jaas_dp; depends on jaas_pkg.
//
// Takes one X/Y sample beat, widens each axis's seen range, and reports the
// deflection of each axis in percent (-100..100) with a direction code.
// One beat is worked at a time: a new beat is taken only once the result of the
// last one has been loaded into the output register, and that load waits while
// a stalled beat is still held there. Each axis in turn passes a setup step, the
// single shared divider, which retires two quotient bits a cycle over eight steps,
// and a store step. A result beat waits in the output register while the next
// sample is taken. Config writes are only legal while idle; a write to a
// range-start register also reloads that seen bound.
module joystick_axis_autocal_scaler_unit import jaas_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_W-1:0]      x_sample,
  input  logic [SAMPLE_W-1:0]      y_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [PCT_W-1:0]  x_percent,
  output logic [DIR_W-1:0]         x_dir,
  output logic signed [PCT_W-1:0]  y_percent,
  output logic [DIR_W-1:0]         y_dir,
  input  logic                     cfg_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SAMPLE_W-1:0]      cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  jaas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  jaas_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .x_sample  (x_sample),
    .y_sample  (y_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_percent (x_percent),
    .x_dir     (x_dir),
    .y_percent (y_percent),
    .y_dir     (y_dir)
  );

endmodule
